// ===== src/dtq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the deadline timer queue: sizes, item and entry types, codes,
// controller states and the entry ordering function. No dependencies.
package dtq_pkg;

    // Queue sizing.
    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_RESULTS = 64;
    localparam int TAG_W       = 16;
    localparam int TIME_W      = 32;
    localparam int ENTRY_W     = TAG_W + TIME_W;

    // Heap index runs 1..QUEUE_DEPTH; the count runs 0..QUEUE_DEPTH.
    localparam int IDX_W       = $clog2(QUEUE_DEPTH + 1);
    // Entries are split by index parity into two banks, address = index >> 1.
    localparam int BANK_DEPTH  = QUEUE_DEPTH / 2 + 1;
    localparam int BANK_AW     = IDX_W - 1;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Command codes of the input item.
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_RUN      = 1'b1;

    // Kind codes of the result item.
    localparam logic KIND_EXPIRED  = 1'b0;
    localparam logic KIND_REJECTED = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] delay;
        logic [TAG_W-1:0]  tag;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [TAG_W-1:0]  tag_res;
        logic [TIME_W-1:0] deadline;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] deadline;
    } t_entry;

    // One bank's write and read request for a cycle.
    typedef struct packed {
        logic               we;
        logic [BANK_AW-1:0] waddr;
        t_entry             wdata;
        logic [BANK_AW-1:0] raddr;
    } t_bank_req;

    // Result handed from the controller to the output stage.
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_push;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_RUN_RD,
        ST_RUN_CHK,
        ST_LAST_RD,
        ST_LAST_WT,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FINISH
    } t_state;

    // True if entry a must leave the queue before entry b.
    function automatic logic entry_before(input t_entry a, input t_entry b);
        logic r;
        if (a.deadline != b.deadline) begin
            r = (a.deadline < b.deadline);
        end else begin
            r = (a.tag < b.tag);
        end
        return r;
    endfunction

endpackage

// ===== src/dtq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read sees writes of earlier cycles.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dtq_out_stage.sv =====
`timescale 1ns / 1ps
// Output register of the deadline timer queue: holds one result item until
// the consumer takes it. Depends on dtq_pkg.
module dtq_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtq_pkg::t_push     i_push,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dtq_pkg::t_out_item o_out_item
);
    import dtq_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // The register can take a new item when empty or being drained this cycle.
    assign o_free = !r_valid || i_out_ready;

    // Valid flag of the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload of the output register.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_item <= i_push.item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    // A new item is only loaded when the register is free.
    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> o_free)
        else $error("result item pushed into a full output register");

endmodule

// ===== src/dtq_ctrl.sv =====
`timescale 1ns / 1ps
// Heap controller of the deadline timer queue: sift-up on register, pop and
// sift-down on run, over two parity banks of entries. Depends on dtq_pkg.
module dtq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dtq_pkg::t_in_item  i_in_item,
    output dtq_pkg::t_push     o_push,
    input  logic               i_out_free,
    output dtq_pkg::t_bank_req o_even_req,
    output dtq_pkg::t_bank_req o_odd_req,
    input  dtq_pkg::t_entry    i_even_rdata,
    input  dtq_pkg::t_entry    i_odd_rdata
);
    import dtq_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    t_entry            r_key, n_key;
    logic [TIME_W-1:0] r_now, n_now;
    logic [NRES_W-1:0] r_nres, n_nres;
    logic              r_pend_valid, n_pend_valid;
    t_out_item         r_pend, n_pend;

    logic              w_accept;
    logic [TIME_W:0]   w_sum;
    logic [TIME_W-1:0] w_deadline;
    logic              w_full;
    logic [IDX_W:0]    w_child;
    logic              w_has_child;
    logic              w_has_right;
    logic              w_take_right;
    t_entry            w_best;
    logic [IDX_W-1:0]  w_best_idx;
    logic              w_child_wins;
    logic [IDX_W-1:0]  w_parent;
    t_entry            w_parent_data;
    logic              w_key_wins;
    t_entry            w_last_data;
    logic              w_root_due;
    logic              w_chk_stall;
    logic              w_run_done;

    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_idx;
    t_entry            w_wr_data;
    logic [BANK_AW-1:0] w_rd_even;
    logic [BANK_AW-1:0] w_rd_odd;

    // Shared decisions of the datapath.
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_sum       = {1'b0, i_in_item.now} + {1'b0, i_in_item.delay};
    assign w_deadline  = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];
    assign w_full      = (r_count == IDX_W'(QUEUE_DEPTH));

    // Sift-down: children of r_idx sit at 2i (even bank) and 2i+1 (odd bank).
    assign w_child      = {r_idx, 1'b0};
    assign w_has_child  = (w_child <= {1'b0, r_count});
    assign w_has_right  = ((w_child + (IDX_W + 1)'(1)) <= {1'b0, r_count});
    assign w_take_right = w_has_right && entry_before(i_odd_rdata, i_even_rdata);
    assign w_best       = w_take_right ? i_odd_rdata : i_even_rdata;
    assign w_best_idx   = {w_child[IDX_W-1:1], w_take_right};
    assign w_child_wins = entry_before(w_best, r_key);

    // Sift-up: the parent of r_idx.
    assign w_parent      = r_idx >> 1;
    assign w_parent_data = w_parent[0] ? i_odd_rdata : i_even_rdata;
    assign w_key_wins    = entry_before(r_key, w_parent_data);

    // Run: root check and the element that refills the root.
    assign w_last_data = r_count[0] ? i_odd_rdata : i_even_rdata;
    assign w_root_due  = (i_odd_rdata.deadline <= r_now);
    assign w_chk_stall = r_pend_valid && !i_out_free;
    assign w_run_done  = (r_count == '0) || (r_nres == NRES_W'(MAX_RESULTS));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.cmd == CMD_RUN) begin
                        n_state = ST_RUN_RD;
                    end else if (w_full) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_UP_RD;
                    end
                end
            end
            ST_UP_RD: begin
                n_state = (r_idx == IDX_W'(1)) ? ST_IDLE : ST_UP_CMP;
            end
            ST_UP_CMP: begin
                n_state = w_key_wins ? ST_UP_RD : ST_IDLE;
            end
            ST_RUN_RD: begin
                n_state = w_run_done ? ST_FINISH : ST_RUN_CHK;
            end
            ST_RUN_CHK: begin
                if (!w_root_due) begin
                    n_state = ST_FINISH;
                end else if (!w_chk_stall) begin
                    n_state = (r_count == IDX_W'(1)) ? ST_RUN_RD : ST_LAST_RD;
                end
            end
            ST_LAST_RD: begin
                n_state = ST_LAST_WT;
            end
            ST_LAST_WT: begin
                n_state = ST_DN_RD;
            end
            ST_DN_RD: begin
                n_state = w_has_child ? ST_DN_CMP : ST_RUN_RD;
            end
            ST_DN_CMP: begin
                n_state = w_child_wins ? ST_DN_RD : ST_RUN_RD;
            end
            ST_FINISH: begin
                if (!r_pend_valid || i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath next values, memory requests and result pushes.
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_key        = r_key;
        n_now        = r_now;
        n_nres       = r_nres;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        w_wr_en      = 1'b0;
        w_wr_idx     = r_idx;
        w_wr_data    = r_key;
        w_rd_even    = '0;
        w_rd_odd     = '0;
        o_push.valid = 1'b0;
        o_push.item  = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_now  = i_in_item.now;
                    n_nres = '0;
                    if (i_in_item.cmd == CMD_REGISTER) begin
                        if (w_full) begin
                            n_pend_valid     = 1'b1;
                            n_pend.kind      = KIND_REJECTED;
                            n_pend.tag_res   = i_in_item.tag;
                            n_pend.deadline  = w_deadline;
                            n_pend.last      = 1'b0;
                        end else begin
                            n_key.tag      = i_in_item.tag;
                            n_key.deadline = w_deadline;
                            n_idx          = r_count + IDX_W'(1);
                            n_count        = r_count + IDX_W'(1);
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (r_idx == IDX_W'(1)) begin
                    w_wr_en = 1'b1;
                end else begin
                    w_rd_even = w_parent[IDX_W-1:1];
                    w_rd_odd  = w_parent[IDX_W-1:1];
                end
            end
            ST_UP_CMP: begin
                w_wr_en = 1'b1;
                if (w_key_wins) begin
                    w_wr_data = w_parent_data;
                    n_idx     = w_parent;
                end
            end
            ST_RUN_RD: begin
                // Root is index 1: odd bank, address 0.
                w_rd_odd = '0;
            end
            ST_RUN_CHK: begin
                w_rd_odd = '0;
                if (w_root_due && !w_chk_stall) begin
                    o_push.valid     = r_pend_valid;
                    o_push.item.last = 1'b0;
                    n_pend_valid     = 1'b1;
                    n_pend.kind      = KIND_EXPIRED;
                    n_pend.tag_res   = i_odd_rdata.tag;
                    n_pend.deadline  = i_odd_rdata.deadline;
                    n_pend.last      = 1'b0;
                    n_nres           = r_nres + NRES_W'(1);
                    if (r_count == IDX_W'(1)) begin
                        n_count = '0;
                    end
                end
            end
            ST_LAST_RD: begin
                w_rd_even = r_count[IDX_W-1:1];
                w_rd_odd  = r_count[IDX_W-1:1];
            end
            ST_LAST_WT: begin
                n_key   = w_last_data;
                n_count = r_count - IDX_W'(1);
                n_idx   = IDX_W'(1);
            end
            ST_DN_RD: begin
                if (w_has_child) begin
                    w_rd_even = r_idx[BANK_AW-1:0];
                    w_rd_odd  = r_idx[BANK_AW-1:0];
                end else begin
                    w_wr_en = 1'b1;
                end
            end
            ST_DN_CMP: begin
                w_wr_en = 1'b1;
                if (w_child_wins) begin
                    w_wr_data = w_best;
                    n_idx     = w_best_idx;
                end
            end
            ST_FINISH: begin
                if (r_pend_valid && i_out_free) begin
                    o_push.valid     = 1'b1;
                    o_push.item.last = 1'b1;
                    n_pend_valid     = 1'b0;
                end
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    // Map the single write and the two reads onto the parity banks.
    always_comb begin
        o_even_req.we    = w_wr_en && !w_wr_idx[0];
        o_even_req.waddr = w_wr_idx[IDX_W-1:1];
        o_even_req.wdata = w_wr_data;
        o_even_req.raddr = w_rd_even;
        o_odd_req.we     = w_wr_en && w_wr_idx[0];
        o_odd_req.waddr  = w_wr_idx[IDX_W-1:1];
        o_odd_req.wdata  = w_wr_data;
        o_odd_req.raddr  = w_rd_odd;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_key  <= n_key;
        r_now  <= n_now;
        r_nres <= n_nres;
        r_pend <= n_pend;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IDX_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending result left behind when going idle");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (w_wr_idx != '0) && (w_wr_idx <= r_count))
        else $error("heap write outside the occupied entries");

    a_push_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> r_pend_valid && i_out_free)
        else $error("result pushed without a pending item or free output");

    a_push_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && (r_state == ST_FINISH)) |=> (r_state == ST_IDLE))
        else $error("final result pushed without ending the item");

endmodule

// ===== src/deadline_timer_queue.sv =====
`timescale 1ns / 1ps
// Top level of the deadline timer queue: binary min-heap of {tag, deadline}
// in two parity RAM banks, heap controller and output register.
// Depends on dtq_pkg, dtq_ram, dtq_ctrl and dtq_out_stage.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+----------------------------
//   input   | i_in_valid  | o_in_ready  | i_in_item  (t_in_item)
//   output  | o_out_valid | i_out_ready | o_out_item (t_out_item)
//
// Register: the new entry is placed last and sifted up toward the root; into a
// full queue it is rejected and returned as a result. Run: while the root is due
// and fewer than MAX_RESULTS results are out, the root is popped as an expired
// result, refilled from the last entry and sifted down; the final one is marked last.
// Input is taken only when idle; the controller waits while a result is pending
// and the output register is still full. Reset is synchronous, no clearing pass.
module deadline_timer_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dtq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dtq_pkg::t_out_item o_out_item
);
    import dtq_pkg::*;

    t_bank_req          w_even_req;
    t_bank_req          w_odd_req;
    logic [ENTRY_W-1:0] w_even_rdata;
    logic [ENTRY_W-1:0] w_odd_rdata;
    t_push              w_push;
    logic               w_out_free;

    // Even heap indices.
    dtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (w_even_req.we),
        .i_waddr (w_even_req.waddr),
        .i_wdata (w_even_req.wdata),
        .i_raddr (w_even_req.raddr),
        .o_rdata (w_even_rdata)
    );

    // Odd heap indices, including the root.
    dtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (w_odd_req.we),
        .i_waddr (w_odd_req.waddr),
        .i_wdata (w_odd_req.wdata),
        .i_raddr (w_odd_req.raddr),
        .o_rdata (w_odd_rdata)
    );

    // Heap controller.
    dtq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push       (w_push),
        .i_out_free   (w_out_free),
        .o_even_req   (w_even_req),
        .o_odd_req    (w_odd_req),
        .i_even_rdata (t_entry'(w_even_rdata)),
        .i_odd_rdata  (t_entry'(w_odd_rdata))
    );

    // Output register.
    dtq_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for deadline_timer_queue: directed and random items,
// a predictor of the deadline queue and a per-field result checker.
// Depends on dtq_pkg and the deadline_timer_queue RTL.

module tb_top;
    import dtq_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS = 460;

    // Idle behavior attached to each item of the stimulus.
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        t_in_item   item;
        t_idle_mode mode;
        logic       drain;   // wait until every pending result has arrived
        logic       hold;    // start a long output hold-off with this item
    } t_stim;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    deadline_timer_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // Stimulus and expectation stores.
    t_stim      pending_items[$];
    t_out_item  expected_results[$];

    // Predictor state: unordered pool of stored timers.
    t_entry     timer_slots[QUEUE_DEPTH];
    int         timer_fill = 0;

    // Generator state.
    t_idle_mode gen_mode = IDLE_NONE;
    logic       gen_drain = 1'b0;
    logic       gen_hold = 1'b0;
    logic [31:0] clock_ms = 32'd1000;
    int         generated = 0;

    // Handshake bookkeeping shared by driver, receiver and monitor.
    logic       in_fire = 1'b0;
    t_idle_mode cur_mode = IDLE_NONE;
    logic       hold_toggle = 1'b0;
    t_stim      drv_item;

    // Statistics and errors.
    int mismatches = 0;
    int n_registers = 0;
    int n_runs = 0;
    int n_results = 0;
    int n_rejects = 0;
    int burst_len = 0;
    int longest_burst = 0;
    int cycle_count = 0;

    // Prints one line for a failed check and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Adds one item to the stimulus with the current idle mode and flags.
    task automatic queue_item(input logic cmd, input logic [31:0] now,
                              input logic [31:0] delay, input logic [15:0] tag);
        t_stim s;
        s.item.cmd   = cmd;
        s.item.now   = now;
        s.item.delay = delay;
        s.item.tag   = tag;
        s.mode  = gen_mode;
        s.drain = gen_drain;
        s.hold  = gen_hold;
        gen_drain = 1'b0;
        gen_hold  = 1'b0;
        pending_items = {pending_items, s};
        generated++;
    endtask

    // Works out the results of one accepted item and updates the timer pool.
    task automatic predict_expiries(input t_in_item it);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] due;
        t_out_item         res;
        int                best;
        int                emitted;
        logic              have_prev;
        logic              stop;
        res = '0;
        if (it.cmd == CMD_REGISTER) begin
            // Deadline saturates at the largest time value.
            sum = {1'b0, it.now} + {1'b0, it.delay};
            due = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            if (timer_fill >= QUEUE_DEPTH) begin
                res.kind     = KIND_REJECTED;
                res.tag_res  = it.tag;
                res.deadline = due;
                res.last     = 1'b1;
                expected_results = {expected_results, res};
            end else begin
                timer_slots[timer_fill].tag      = it.tag;
                timer_slots[timer_fill].deadline = due;
                timer_fill++;
            end
        end else begin
            // Pop the earliest {deadline, tag} while it is due, up to the limit.
            emitted   = 0;
            have_prev = 1'b0;
            stop      = 1'b0;
            while (!stop && emitted < MAX_RESULTS && timer_fill > 0) begin
                best = 0;
                for (int i = 1; i < timer_fill; i++) begin
                    if ({timer_slots[i].deadline, timer_slots[i].tag} <
                        {timer_slots[best].deadline, timer_slots[best].tag}) begin
                        best = i;
                    end
                end
                if (timer_slots[best].deadline > it.now) begin
                    stop = 1'b1;
                end else begin
                    if (have_prev) begin
                        expected_results = {expected_results, res};
                    end
                    res.kind     = KIND_EXPIRED;
                    res.tag_res  = timer_slots[best].tag;
                    res.deadline = timer_slots[best].deadline;
                    res.last     = 1'b0;
                    have_prev    = 1'b1;
                    timer_slots[best] = timer_slots[timer_fill-1];
                    timer_fill--;
                    emitted++;
                end
            end
            if (have_prev) begin
                res.last = 1'b1;
                expected_results = {expected_results, res};
            end
        end
    endtask

    // Compares one accepted result with the oldest expectation.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, tag", 32'(got.tag_res), '0);
        end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.tag_res !== want.tag_res)
                report_mismatch("tag_res", 32'(got.tag_res), 32'(want.tag_res));
            if (got.deadline !== want.deadline)
                report_mismatch("deadline", got.deadline, want.deadline);
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
        end
    endtask

    function automatic logic roll_percent(input int pct);
        return ($urandom_range(99) < pct);
    endfunction

    // Driver: offers the next item at the falling edge, holding it until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_items.size() == 0 ||
                (pending_items[0].drain && expected_results.size() != 0) ||
                (pending_items[0].mode == IDLE_SENDER && roll_percent(63)) ||
                (pending_items[0].mode == IDLE_BOTH && roll_percent(12))) begin
                i_in_valid <= 1'b0;
            end else begin
                drv_item = pending_items.pop_front();
                i_in_item  <= drv_item.item;
                i_in_valid <= 1'b1;
                cur_mode   <= drv_item.mode;
                if (drv_item.hold) begin
                    hold_toggle <= ~hold_toggle;
                end
            end
        end
    end

    // Receiver: random stalls by mode, plus a long hold-off on request.
    int   hold_left = 0;
    logic hold_seen = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (cur_mode == IDLE_RECEIVER) begin
            i_out_ready <= !roll_percent(63);
        end else if (cur_mode == IDLE_BOTH) begin
            i_out_ready <= !roll_percent(12);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: predicts on accepted items and checks accepted results.
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (i_in_item.cmd == CMD_REGISTER) n_registers++;
                else n_runs++;
                predict_expiries(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                n_results++;
                burst_len++;
                if (o_out_item.kind == KIND_REJECTED) n_rejects++;
                if (o_out_item.last) begin
                    if (burst_len > longest_burst) longest_burst = burst_len;
                    burst_len = 0;
                end
                check_result(o_out_item);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Stimulus build, reset and end of run.
    int    rand_start;
    int    fills;
    int    pick;
    int    burst;
    logic [31:0] span;
    logic [15:0] tag_base;
    initial begin
        // Directed: field extremes, saturation, ties, duplicates, empty runs.
        gen_mode = IDLE_NONE;
        queue_item(CMD_RUN, 32'd0, 32'd0, 16'd0);
        queue_item(CMD_REGISTER, 32'd0, 32'd0, 16'hFFFF);
        queue_item(CMD_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        queue_item(CMD_REGISTER, 32'd100, 32'd50, 16'h1234);
        queue_item(CMD_REGISTER, 32'd100, 32'd50, 16'h1234);
        queue_item(CMD_REGISTER, 32'h8000_0000, 32'h7FFF_FFFF, 16'd5);
        queue_item(CMD_REGISTER, 32'd150, 32'd0, 16'd7);
        queue_item(CMD_REGISTER, 32'h0000_0001, 32'hFFFF_FFFF, 16'd9);
        queue_item(CMD_RUN, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(CMD_RUN, 32'd149, 32'd0, 16'd0);
        queue_item(CMD_RUN, 32'd150, 32'd0, 16'd0);
        queue_item(CMD_RUN, 32'hFFFF_FFFE, 32'd0, 16'd0);
        queue_item(CMD_RUN, 32'hFFFF_FFFF, 32'd0, 16'd0);
        queue_item(CMD_RUN, 32'hFFFF_FFFF, 32'd0, 16'd0);

        // Random: mostly timed bursts followed by a run, some noise, and
        // two sequences that fill the queue past its depth.
        rand_start = generated;
        fills = 0;
        gen_drain = 1'b1;
        while (generated - rand_start < RANDOM_ITEMS) begin
            gen_mode = t_idle_mode'(((generated - rand_start) / 60) % 4);
            pick = $urandom_range(99);
            if ((fills == 0 && generated - rand_start >= 100) ||
                (fills == 1 && generated - rand_start >= 300)) begin
                if (fills == 0) gen_mode = IDLE_NONE;
                burst = $urandom_range(66, 72);
                for (int k = 0; k < burst; k++) begin
                    queue_item(CMD_REGISTER, $urandom, $urandom, 16'($urandom));
                end
                gen_hold = (fills == 0);
                queue_item(CMD_RUN, 32'hFFFF_FFFF, $urandom, 16'($urandom));
                // Keep offering items while the results are pending (output held off in the first).
                for (int k = 0; k < 4; k++) begin
                    queue_item(CMD_REGISTER, clock_ms, 32'($urandom_range(0, 50)),
                               16'($urandom));
                end
                gen_drain = 1'b1;
                fills++;
            end else if (pick < 55) begin
                burst = $urandom_range(1, 10);
                for (int k = 0; k < burst; k++) begin
                    span = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 300);
                    tag_base = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 3))
                                                        : 16'($urandom);
                    queue_item(CMD_REGISTER, clock_ms, span, tag_base);
                    clock_ms = clock_ms + $urandom_range(0, 40);
                end
                clock_ms = clock_ms + $urandom_range(0, 300);
                queue_item(CMD_RUN, clock_ms, $urandom, 16'($urandom));
            end else if (pick < 70) begin
                // Equal deadlines so that the tag decides the order.
                burst = $urandom_range(2, 6);
                span = $urandom_range(0, 100);
                tag_base = 16'($urandom);
                for (int k = 0; k < burst; k++) begin
                    queue_item(CMD_REGISTER, clock_ms, span,
                               tag_base ^ 16'($urandom_range(0, 3)));
                end
                clock_ms = clock_ms + span;
                queue_item(CMD_RUN, clock_ms, $urandom, 16'($urandom));
            end else begin
                queue_item(1'($urandom_range(1)), $urandom, $urandom, 16'($urandom));
            end
        end
        gen_mode = IDLE_NONE;
        queue_item(CMD_RUN, 32'hFFFF_FFFF, 32'd0, 16'd0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d register and %0d run items, %0d results",
                 n_registers, n_runs, n_results);
        $display("including %0d rejections; longest burst %0d; %0d mismatches",
                 n_rejects, longest_burst, mismatches);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
